// ===== sv/fssm_pkg.sv =====
package fssm_pkg;

  // Application-layer state codes (one-hot nibble; BOOT, only ever a request, is not one-hot)
  localparam logic [3:0] ST_INIT   = 4'd1;
  localparam logic [3:0] ST_PREOP  = 4'd2;
  localparam logic [3:0] ST_BOOT   = 4'd3;
  localparam logic [3:0] ST_SAFEOP = 4'd4;
  localparam logic [3:0] ST_OP     = 4'd8;

  // Status codes
  localparam logic [2:0] SC_NONE     = 3'd0;
  localparam logic [2:0] SC_INVALID  = 3'd1;
  localparam logic [2:0] SC_UNKNOWN  = 3'd2;
  localparam logic [2:0] SC_BOOT     = 3'd3;
  localparam logic [2:0] SC_MAILBOX  = 3'd4;
  localparam logic [2:0] SC_WATCHDOG = 3'd5;
  localparam logic [2:0] SC_PDO      = 3'd6;

  typedef struct packed {
    logic [3:0] requested_state;
    logic       fault_ack;
    logic       mailbox_setup_ok;
    logic       mailbox_config_valid;
    logic       pdo_setup_ok;
    logic [3:0] pdo_fault;
    logic       output_data_valid;
    logic       watchdog_expired;
  } in_t;

  typedef struct packed {
    logic [3:0] al_state;
    logic       error_flag;
    logic [2:0] status_code;
    logic [3:0] pdo_detail;
  } out_t;

  // Contents of the input holding register
  typedef struct packed {
    logic valid;
    in_t  item;
  } in_slot_t;

  localparam out_t STATUS_RESET = '{
    al_state:    ST_INIT,
    error_flag:  1'b0,
    status_code: SC_NONE,
    pdo_detail:  4'd0
  };

endpackage

// ===== sv/fssm_in_stage.sv =====
module fssm_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fssm_pkg::in_t      in_item,
  input  logic               advance,
  output fssm_pkg::in_slot_t slot
);

  fssm_pkg::in_slot_t held;

  // Take a new word when empty or when the held one moves on this cycle
  assign in_ready = !held.valid || advance;
  assign slot     = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (in_ready) begin
      held.valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held.item <= in_item;
    end
  end

endmodule

// ===== sv/fssm_rules.sv =====
module fssm_rules (
  input  fssm_pkg::in_t  item,
  input  fssm_pkg::out_t status,
  input  logic           mailbox_present,
  output fssm_pkg::out_t status_next
);

  logic [3:0] req;
  logic [3:0] cur;
  logic       known;
  logic       mbx_bad;
  logic [3:0] nst;
  logic [2:0] ncode;
  logic [3:0] det_src;

  always_comb begin
    req     = item.requested_state;
    cur     = status.al_state;
    known   = (req == fssm_pkg::ST_INIT)   || (req == fssm_pkg::ST_PREOP) ||
              (req == fssm_pkg::ST_BOOT)   || (req == fssm_pkg::ST_SAFEOP) ||
              (req == fssm_pkg::ST_OP);
    mbx_bad = mailbox_present && !item.mailbox_config_valid;
    nst     = cur;
    ncode   = fssm_pkg::SC_NONE;
    det_src = item.pdo_fault;

    if (status.error_flag && !item.fault_ack) begin
      // Pending error: only an INIT request clears it
      if (req == fssm_pkg::ST_INIT) begin
        nst = fssm_pkg::ST_INIT;
      end else begin
        ncode   = status.status_code;
        det_src = status.pdo_detail;
      end
    end else if (cur != fssm_pkg::ST_OP && !known) begin
      ncode = fssm_pkg::SC_UNKNOWN;
    end else begin
      case (cur)
        fssm_pkg::ST_PREOP: begin
          if (mbx_bad) begin
            nst   = fssm_pkg::ST_INIT;
            ncode = fssm_pkg::SC_MAILBOX;
          end else if (req == fssm_pkg::ST_SAFEOP) begin
            if (!item.pdo_setup_ok) begin
              nst = fssm_pkg::ST_PREOP;
            end else if (item.pdo_fault != 4'd0) begin
              nst   = fssm_pkg::ST_PREOP;
              ncode = fssm_pkg::SC_PDO;
            end else begin
              nst = fssm_pkg::ST_SAFEOP;
            end
          end else if (req == fssm_pkg::ST_INIT) begin
            nst = fssm_pkg::ST_INIT;
          end else if (req == fssm_pkg::ST_OP || req == fssm_pkg::ST_BOOT) begin
            nst   = fssm_pkg::ST_PREOP;
            ncode = fssm_pkg::SC_INVALID;
          end else begin
            nst = fssm_pkg::ST_PREOP;
          end
        end
        fssm_pkg::ST_SAFEOP: begin
          if (mbx_bad) begin
            nst   = fssm_pkg::ST_INIT;
            ncode = fssm_pkg::SC_MAILBOX;
          end else if (item.pdo_fault != 4'd0) begin
            nst   = fssm_pkg::ST_PREOP;
            ncode = fssm_pkg::SC_PDO;
          end else if (req == fssm_pkg::ST_OP && item.output_data_valid) begin
            nst = fssm_pkg::ST_OP;
          end else if (req == fssm_pkg::ST_PREOP || req == fssm_pkg::ST_INIT) begin
            nst = req;
          end else if (req == fssm_pkg::ST_BOOT) begin
            nst   = fssm_pkg::ST_SAFEOP;
            ncode = fssm_pkg::SC_INVALID;
          end else begin
            nst = fssm_pkg::ST_SAFEOP;
          end
        end
        fssm_pkg::ST_OP: begin
          if (item.watchdog_expired) begin
            nst   = fssm_pkg::ST_SAFEOP;
            ncode = fssm_pkg::SC_WATCHDOG;
          end else if (mbx_bad) begin
            nst   = fssm_pkg::ST_INIT;
            ncode = fssm_pkg::SC_MAILBOX;
          end else if (item.pdo_fault != 4'd0) begin
            nst   = fssm_pkg::ST_PREOP;
            ncode = fssm_pkg::SC_PDO;
          end else if (req == fssm_pkg::ST_BOOT) begin
            nst   = fssm_pkg::ST_SAFEOP;
            ncode = fssm_pkg::SC_INVALID;
          end else if (req == fssm_pkg::ST_PREOP || req == fssm_pkg::ST_INIT ||
                       req == fssm_pkg::ST_SAFEOP) begin
            nst = req;
          end else if (req != fssm_pkg::ST_OP) begin
            nst   = fssm_pkg::ST_SAFEOP;
            ncode = fssm_pkg::SC_UNKNOWN;
          end else begin
            nst = fssm_pkg::ST_OP;
          end
        end
        default: begin
          // INIT, and any stray state value
          nst = fssm_pkg::ST_INIT;
          if (req == fssm_pkg::ST_PREOP &&
              (!mailbox_present || (item.mailbox_setup_ok && item.mailbox_config_valid))) begin
            nst = fssm_pkg::ST_PREOP;
          end else if (req == fssm_pkg::ST_PREOP && item.mailbox_setup_ok) begin
            ncode = fssm_pkg::SC_MAILBOX;
          end else if (req == fssm_pkg::ST_SAFEOP || req == fssm_pkg::ST_OP) begin
            ncode = fssm_pkg::SC_INVALID;
          end else if (req == fssm_pkg::ST_BOOT) begin
            ncode = fssm_pkg::SC_BOOT;
          end
        end
      endcase
    end

    status_next.al_state    = nst;
    status_next.error_flag  = (ncode != fssm_pkg::SC_NONE);
    status_next.status_code = ncode;
    status_next.pdo_detail  = (ncode == fssm_pkg::SC_PDO) ? det_src : 4'd0;
  end

endmodule

// ===== sv/fieldbus_slave_state_machine_unit.sv =====
// Application-layer state machine of a fieldbus slave (INIT, PRE_OP, SAFE_OP, OP).
//
// Input channel (in_valid / in_ready / in_item): one control event per word,
// carrying the requested state and the current mailbox / process-data check
// results. Output channel (out_valid / out_ready / out_item): exactly one
// status word per event, in order: resulting state, error flag, status code
// and process-data fault detail.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes the single
// mailbox_present bit; always ready. Write it only while no event is in flight.
//
// An accepted event passes through two registers, the input holding register and
// then the status register, before its status word is valid.
// Throughput: one event per cycle while out_ready is high, set by the combinational
// transition logic reading the status register, which is itself the machine state.
// Reset (rst, synchronous): state INIT with no error, mailbox_present = 1,
// both registers empty.
// Stall: while out_ready is low the status word holds; one more event can
// wait in the input register, after which in_ready drops.
module fieldbus_slave_state_machine_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fssm_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fssm_pkg::out_t out_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  fssm_pkg::in_slot_t slot;
  fssm_pkg::out_t     status;
  fssm_pkg::out_t     status_next;
  logic               mailbox_present;
  logic               advance;

  // Move the held event into the status register when the output slot frees up
  assign advance = slot.valid && (!out_valid || out_ready);

  fssm_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .slot     (slot)
  );

  // Transition rules read the stored status as the current state
  fssm_rules u_rules (
    .item            (slot.item),
    .status          (status),
    .mailbox_present (mailbox_present),
    .status_next     (status_next)
  );

  assign cfg_ready = 1'b1;
  assign out_item  = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      mailbox_present <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mailbox_present <= cfg_data;
    end
  end

  // Status register doubles as the state: update it and raise valid together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      status    <= fssm_pkg::STATUS_RESET;
    end else if (advance) begin
      out_valid <= 1'b1;
      status    <= status_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/fssm_checker.sv =====
module fssm_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input fssm_pkg::out_t out_item
);

  // Resulting state is always one of INIT, PRE_OP, SAFE_OP, OP
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_item.al_state))
    else $error("al_state not one-hot");

  // Error flag mirrors a nonzero status code
  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.error_flag == (out_item.status_code != fssm_pkg::SC_NONE)))
    else $error("error_flag disagrees with status_code");

  // Fault detail only accompanies a process-data fault
  a_detail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.pdo_detail != 4'd0) |-> (out_item.status_code == fssm_pkg::SC_PDO))
    else $error("pdo_detail without pdo fault code");

  // Stalled status word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("status word changed under stall");

endmodule

bind fieldbus_slave_state_machine_unit fssm_checker u_fssm_checker (.*);

// ===== tb/sv/tb_fieldbus_slave_state_machine_unit.sv =====
`timescale 1ns / 100ps

module tb_fieldbus_slave_state_machine_unit;

  // Generous bound on the whole run: ~1100 events, each held up at worst by sender
  // gaps plus receiver stalls at 68 percent.
  localparam int CYCLE_LIMIT     = 200000;
  localparam int EVENTS_PER_PASS = 345;
  // Two registers from event to status word; leave some slack.
  localparam int SETTLE_CYCLES   = 6;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  fssm_pkg::in_t  in_item   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  fssm_pkg::out_t out_item;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_data  = 1'b0;

  // Shadow of the slave: mailbox_present register and the held status.
  logic       mailbox_present_shadow = 1'b1;
  logic [3:0] tracked_state;
  logic       tracked_err;
  logic [2:0] tracked_code;
  logic [3:0] tracked_detail;

  fssm_pkg::in_t  pending_events[$];
  fssm_pkg::out_t expected_status[$];

  int sender_idle_pct    = 25;
  int receiver_stall_pct = 68;
  int fail_count         = 0;
  int cycle_count        = 0;

  fieldbus_slave_state_machine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the status word one control event produces from the held status.
  function automatic fssm_pkg::out_t next_status(fssm_pkg::in_t ev);
    logic [3:0]     req;
    logic [3:0]     st;
    logic [2:0]     sc;
    logic [3:0]     det;
    logic           mbx_bad;
    logic           known;
    fssm_pkg::out_t res;
    req     = ev.requested_state;
    mbx_bad = mailbox_present_shadow && !ev.mailbox_config_valid;
    known   = (req == fssm_pkg::ST_INIT) || (req == fssm_pkg::ST_PREOP) ||
              (req == fssm_pkg::ST_BOOT) || (req == fssm_pkg::ST_SAFEOP) ||
              (req == fssm_pkg::ST_OP);
    st  = tracked_state;
    sc  = fssm_pkg::SC_NONE;
    det = 4'd0;
    if (tracked_err && !ev.fault_ack) begin
      // Unacknowledged error: only an INIT request clears it.
      if (req == fssm_pkg::ST_INIT) begin
        st = fssm_pkg::ST_INIT;
      end else begin
        sc  = tracked_code;
        det = tracked_detail;
      end
    end else if (tracked_state != fssm_pkg::ST_OP && !known) begin
      sc = fssm_pkg::SC_UNKNOWN;
    end else begin
      case (tracked_state)
        fssm_pkg::ST_PREOP: begin
          if (mbx_bad) begin
            st = fssm_pkg::ST_INIT;
            sc = fssm_pkg::SC_MAILBOX;
          end else if (req == fssm_pkg::ST_SAFEOP) begin
            if (ev.pdo_setup_ok) begin
              if (ev.pdo_fault != 4'd0) begin
                sc  = fssm_pkg::SC_PDO;
                det = ev.pdo_fault;
              end else begin
                st = fssm_pkg::ST_SAFEOP;
              end
            end
          end else if (req == fssm_pkg::ST_INIT) begin
            st = fssm_pkg::ST_INIT;
          end else if (req == fssm_pkg::ST_OP || req == fssm_pkg::ST_BOOT) begin
            sc = fssm_pkg::SC_INVALID;
          end
        end
        fssm_pkg::ST_SAFEOP: begin
          if (mbx_bad) begin
            st = fssm_pkg::ST_INIT;
            sc = fssm_pkg::SC_MAILBOX;
          end else if (ev.pdo_fault != 4'd0) begin
            st  = fssm_pkg::ST_PREOP;
            sc  = fssm_pkg::SC_PDO;
            det = ev.pdo_fault;
          end else if (req == fssm_pkg::ST_OP && ev.output_data_valid) begin
            st = fssm_pkg::ST_OP;
          end else if (req == fssm_pkg::ST_PREOP || req == fssm_pkg::ST_INIT) begin
            st = req;
          end else if (req == fssm_pkg::ST_BOOT) begin
            sc = fssm_pkg::SC_INVALID;
          end
        end
        fssm_pkg::ST_OP: begin
          if (ev.watchdog_expired) begin
            st = fssm_pkg::ST_SAFEOP;
            sc = fssm_pkg::SC_WATCHDOG;
          end else if (mbx_bad) begin
            st = fssm_pkg::ST_INIT;
            sc = fssm_pkg::SC_MAILBOX;
          end else if (ev.pdo_fault != 4'd0) begin
            st  = fssm_pkg::ST_PREOP;
            sc  = fssm_pkg::SC_PDO;
            det = ev.pdo_fault;
          end else if (req == fssm_pkg::ST_BOOT) begin
            st = fssm_pkg::ST_SAFEOP;
            sc = fssm_pkg::SC_INVALID;
          end else if (req == fssm_pkg::ST_PREOP || req == fssm_pkg::ST_INIT ||
                       req == fssm_pkg::ST_SAFEOP) begin
            st = req;
          end else if (req != fssm_pkg::ST_OP) begin
            st = fssm_pkg::ST_SAFEOP;
            sc = fssm_pkg::SC_UNKNOWN;
          end
        end
        default: begin
          // INIT, and any state value that is not one of the four
          st = fssm_pkg::ST_INIT;
          if (req == fssm_pkg::ST_PREOP && (!mailbox_present_shadow ||
              (ev.mailbox_setup_ok && ev.mailbox_config_valid))) begin
            st = fssm_pkg::ST_PREOP;
          end else if (req == fssm_pkg::ST_PREOP && ev.mailbox_setup_ok) begin
            sc = fssm_pkg::SC_MAILBOX;
          end else if (req == fssm_pkg::ST_SAFEOP || req == fssm_pkg::ST_OP) begin
            sc = fssm_pkg::SC_INVALID;
          end else if (req == fssm_pkg::ST_BOOT) begin
            sc = fssm_pkg::SC_BOOT;
          end
        end
      endcase
    end
    if (sc != fssm_pkg::SC_PDO) begin
      det = 4'd0;
    end
    res.al_state    = st;
    res.error_flag  = (sc != fssm_pkg::SC_NONE);
    res.status_code = sc;
    res.pdo_detail  = det;
    return res;
  endfunction

  function automatic fssm_pkg::in_t make_event(logic [3:0] req, int ack, int mbx_setup,
                                               int mbx_valid, int pdo_setup,
                                               logic [3:0] fault, int odv, int wdog);
    fssm_pkg::in_t ev;
    ev.requested_state      = req;
    ev.fault_ack            = 1'(ack);
    ev.mailbox_setup_ok     = 1'(mbx_setup);
    ev.mailbox_config_valid = 1'(mbx_valid);
    ev.pdo_setup_ok         = 1'(pdo_setup);
    ev.pdo_fault            = fault;
    ev.output_data_valid    = 1'(odv);
    ev.watchdog_expired     = 1'(wdog);
    return ev;
  endfunction

  // Random check results; fault_pct sets how often each check goes wrong (the watchdog at half that rate).
  function automatic fssm_pkg::in_t random_event(logic [3:0] req, int fault_pct);
    fssm_pkg::in_t ev;
    ev.requested_state      = req;
    ev.fault_ack            = ($urandom_range(99) < 75);
    ev.mailbox_setup_ok     = ($urandom_range(99) >= fault_pct);
    ev.mailbox_config_valid = ($urandom_range(99) >= fault_pct);
    ev.pdo_setup_ok         = ($urandom_range(99) >= fault_pct);
    ev.pdo_fault            = ($urandom_range(99) < fault_pct) ? 4'($urandom_range(1, 15))
                                                                : 4'd0;
    ev.output_data_valid    = ($urandom_range(99) >= fault_pct);
    ev.watchdog_expired     = ($urandom_range(99) < fault_pct / 2);
    return ev;
  endfunction

  // Walk the machine through a directed sequence of its rules, starting from INIT after reset
  // with the mailbox present.
  task automatic push_directed();
    pending_events.push_back(make_event(fssm_pkg::ST_BOOT,   0, 0, 1, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_PREOP,  0, 1, 1, 1, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_INIT,   0, 0, 1, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(4'hF,                1, 1, 1, 1, 4'hF, 1, 1));
    pending_events.push_back(make_event(fssm_pkg::ST_SAFEOP, 1, 1, 1, 1, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_PREOP,  1, 0, 1, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_PREOP,  1, 1, 0, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_PREOP,  1, 1, 1, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_BOOT,   0, 1, 1, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_PREOP,  1, 1, 1, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_SAFEOP, 1, 1, 1, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_SAFEOP, 1, 1, 1, 1, 4'hF, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_SAFEOP, 1, 1, 1, 1, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     0, 1, 1, 1, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     0, 1, 1, 1, 4'h0, 1, 0));
    pending_events.push_back(make_event(4'h0,                0, 1, 1, 1, 4'h0, 1, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     1, 1, 1, 1, 4'h0, 1, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     0, 1, 1, 1, 4'h0, 1, 1));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     1, 1, 1, 1, 4'h0, 1, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     0, 1, 1, 1, 4'h5, 1, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_SAFEOP, 1, 1, 1, 1, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     1, 1, 1, 1, 4'h0, 1, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_OP,     0, 1, 0, 1, 4'h0, 1, 0));
    pending_events.push_back(make_event(4'h0,                0, 0, 0, 0, 4'h0, 0, 0));
    pending_events.push_back(make_event(fssm_pkg::ST_INIT,   1, 1, 1, 1, 4'h0, 0, 0));
  endtask

  // Mostly clean bring-up sequences (an optional INIT, PRE_OP, SAFE_OP, OP, then one to five
  // mostly OP events) so the upper states get exercised; the rest is noisy events.
  task automatic push_random(int n);
    int count;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(3) == 0) begin
          pending_events.push_back(random_event(fssm_pkg::ST_INIT, 4));
          count++;
        end
        pending_events.push_back(random_event(fssm_pkg::ST_PREOP, 4));
        pending_events.push_back(random_event(fssm_pkg::ST_SAFEOP, 4));
        pending_events.push_back(random_event(fssm_pkg::ST_OP, 4));
        count += 3;
        repeat ($urandom_range(1, 5)) begin
          pending_events.push_back(random_event(($urandom_range(99) < 80) ? fssm_pkg::ST_OP
                                                : 4'($urandom_range(15)), 4));
          count++;
        end
      end else begin
        pending_events.push_back(random_event(4'($urandom_range(15)), 40));
        count++;
      end
    end
  endtask

  // Hold until every queued event is sent and every status word is back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write mailbox_present; only call while the slave is idle.
  task automatic write_mailbox_present(logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    mailbox_present_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  // Event driver: predict each accepted word, then present the next one
  // unless this cycle is an idle one.
  always @(posedge clk) begin : event_driver
    fssm_pkg::out_t predicted;
    if (rst) begin
      in_valid       <= 1'b0;
      tracked_state  = fssm_pkg::ST_INIT;
      tracked_err    = 1'b0;
      tracked_code   = fssm_pkg::SC_NONE;
      tracked_detail = 4'd0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = next_status(in_item);
        expected_status.push_back(predicted);
        tracked_state  = predicted.al_state;
        tracked_err    = predicted.error_flag;
        tracked_code   = predicted.status_code;
        tracked_detail = predicted.pdo_detail;
      end
      // Hold a word that is still waiting; otherwise advance or go idle.
      if (!in_valid || in_ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_events.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin : status_monitor
    fssm_pkg::out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("status word with no event outstanding: %p", out_item);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (out_item.al_state !== want.al_state) begin
            $error("al_state expected %0d, got %0d", want.al_state, out_item.al_state);
            fail_count++;
          end
          if (out_item.error_flag !== want.error_flag) begin
            $error("error_flag expected %0d, got %0d", want.error_flag, out_item.error_flag);
            fail_count++;
          end
          if (out_item.status_code !== want.status_code) begin
            $error("status_code expected %0d, got %0d",
                   want.status_code, out_item.status_code);
            fail_count++;
          end
          if (out_item.pdo_detail !== want.pdo_detail) begin
            $error("pdo_detail expected %0d, got %0d", want.pdo_detail, out_item.pdo_detail);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Pass 1: mailbox present (reset value), mostly busy sender, slow receiver.
    @(negedge clk);
    push_directed();
    push_random(EVENTS_PER_PASS);
    wait_drained();

    // Pass 2: no mailbox, so every mailbox check is skipped.
    write_mailbox_present(1'b0);
    @(negedge clk);
    sender_idle_pct    = 68;
    receiver_stall_pct = 25;
    push_random(EVENTS_PER_PASS);
    wait_drained();

    // Pass 3: mailbox back, full rate on both sides.
    write_mailbox_present(1'b1);
    @(negedge clk);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    push_random(EVENTS_PER_PASS);
    wait_drained();

    if (fail_count == 0 && expected_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
